FILE: rtl/tws_pkg.sv
// Shared types, constants and controller/datapath interface for the speed stepper.
package tws_pkg;

    localparam int unsigned WINDOW_DEFAULT = 10;

    // Field widths
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned RPM_W    = 16;
    localparam int unsigned DUTY_W   = 14;
    localparam int unsigned TARGET_W = 7;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 8;

    // Sums hold up to 64 * 65535, which also covers the rpm numerator
    localparam int unsigned DIV_W  = 22;
    localparam int unsigned DVSR_W = 16;

    localparam logic [DIV_W-1:0]    RPM_NUMERATOR   = DIV_W'(2000000);
    localparam logic [RPM_W-1:0]    RPM_MAX         = '1;
    localparam logic [DUTY_W-1:0]   DUTY_STEP       = DUTY_W'(100);
    localparam logic [DUTY_W-1:0]   DUTY_HIGH_LIMIT = DUTY_W'(14898);
    localparam logic [DUTY_W-1:0]   DUTY_RESET      = DUTY_W'(3750);
    localparam logic [TARGET_W-1:0] TARGET_RESET    = TARGET_W'(100);
    localparam int unsigned         DEADBAND        = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEFT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RIGHT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEFT_RPM,
        ST_RIGHT_RPM,
        ST_EMIT
    } state_t;

    typedef enum logic [0:0] {
        SEL_LEFT_RPM,
        SEL_RIGHT_RPM
    } div_sel_t;

    typedef struct packed {
        logic     in_ready;
        logic     div_start;
        div_sel_t div_sel;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic win_end;
        logic div_busy;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/tach_window_speed_stepper.sv
// Windowed tachometer speed measurement with a bang-bang duty stepper (top level).
// Each input beat carries one left and one right tachometer period; beats that do not
// complete a window of WINDOW samples are taken back to back while idle and give no
// result. On the beat that completes a window, each wheel's average comes from a
// reciprocal multiplication of its window sum, and one shared restoring divider (one
// quotient bit per cycle, 22 bits) divides 2000000 by the left and then the right
// average. The result is then loaded into the output register, and the next beat is
// taken only after that, or later while an earlier result still waits in the output
// register. Rpm saturates at 65535 and raises the saturation flag, as does a zero average.
// Each duty steps by 100 towards its target with a 3 rpm deadband. Targets are written over
// the configuration channel; the user must write them only while idle (the block does not check).
module tach_window_speed_stepper #(
    parameter int unsigned WINDOW = tws_pkg::WINDOW_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // left_period[15:0], right_period[31:16]
    input  logic                           s_tuser,   // restart
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // left_rpm[15:0], right_rpm[31:16], left_duty[45:32], right_duty[59:46], zero[63:60]
    output logic [63:0]                    m_tdata,
    output logic                           m_tuser,   // speed_saturated
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tws_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tws_pkg::*;

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [RPM_W-1:0]   left_rpm;
    logic [RPM_W-1:0]   right_rpm;
    logic [DUTY_W-1:0]  left_duty;
    logic [DUTY_W-1:0]  right_duty;
    logic               speed_saturated;

    assign cfg_ready = 1'b1;
    assign s_tready  = cmd.in_ready;

    tws_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    tws_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_tvalid        (s_tvalid),
        .left_period     (s_tdata[15:0]),
        .right_period    (s_tdata[31:16]),
        .restart         (s_tuser),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .left_rpm        (left_rpm),
        .right_rpm       (right_rpm),
        .left_duty       (left_duty),
        .right_duty      (right_duty),
        .speed_saturated (speed_saturated)
    );

    assign m_tdata = {4'b0000, right_duty, left_duty, right_rpm, left_rpm};
    assign m_tuser = speed_saturated;

endmodule

FILE: rtl/tws_divider.sv
// Restoring divider, one quotient bit per cycle, shared by both rpm divisions.
module tws_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [tws_pkg::DIV_W-1:0]  dividend,
    input  logic [tws_pkg::DVSR_W-1:0] divisor,
    output logic                       busy,
    output logic                       done,
    output logic [tws_pkg::DIV_W-1:0]  quotient
);
    import tws_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DVSR_W-1:0] rem_reg, rem_next;
    logic [DVSR_W-1:0] dvsr_reg, dvsr_next;
    logic [DVSR_W:0]   trial;
    logic [DVSR_W:0]   diff;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvsr_reg};
    assign fits  = (trial >= {1'b0, dvsr_reg});

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvsr_next  = dvsr_reg;
        if (busy_reg) begin
            // shift in one quotient bit; for a nonzero divisor the remainder stays below it
            quo_next   = {quo_reg[DIV_W-2:0], fits};
            rem_next   = fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
            count_next = count_reg + CNT_W'(1);
            if (count_reg == CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next  = 1'b1;
            count_next = '0;
            quo_next   = dividend;
            rem_next   = '0;
            dvsr_next  = divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/tws_datapath.sv
// Window sums, divider operand selection, rpm and duty registers, output register.
module tws_datapath #(
    parameter int unsigned WINDOW = tws_pkg::WINDOW_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tws_pkg::dp_cmd_t               cmd,
    output tws_pkg::dp_status_t            status,
    input  logic                           s_tvalid,
    input  logic [tws_pkg::PERIOD_W-1:0]   left_period,
    input  logic [tws_pkg::PERIOD_W-1:0]   right_period,
    input  logic                           restart,
    input  logic                           cfg_we,
    input  logic [tws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tws_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tws_pkg::RPM_W-1:0]      left_rpm,
    output logic [tws_pkg::RPM_W-1:0]      right_rpm,
    output logic [tws_pkg::DUTY_W-1:0]     left_duty,
    output logic [tws_pkg::DUTY_W-1:0]     right_duty,
    output logic                           speed_saturated
);
    import tws_pkg::*;

    localparam int unsigned CNT_W       = $clog2(WINDOW + 1);
    localparam int unsigned RECIP_SHIFT = 28;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
    localparam int unsigned PROD_W      = RECIP_SHIFT + DVSR_W;
    // ceil(2^28 / WINDOW): the floored average is exact for any sum below 2^22
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + WINDOW - 1) / WINDOW);

    function automatic logic [DUTY_W-1:0] step_duty(
        input logic [DUTY_W-1:0]   duty,
        input logic [RPM_W-1:0]    rpm,
        input logic [TARGET_W-1:0] target
    );
        logic [RPM_W:0] rpm_x;
        logic [RPM_W:0] tgt_x;
        logic [DUTY_W-1:0] res;
        rpm_x = {1'b0, rpm};
        tgt_x = (RPM_W + 1)'(target);
        res   = duty;
        // rpm < target - 3 written as rpm + 3 < target, so small targets never raise
        if ((rpm_x > tgt_x + (RPM_W + 1)'(DEADBAND)) && (duty > DUTY_STEP)) begin
            res = duty - DUTY_STEP;
        end else if ((rpm_x + (RPM_W + 1)'(DEADBAND) < tgt_x) && (duty < DUTY_HIGH_LIMIT)) begin
            res = duty + DUTY_STEP;
        end
        return res;
    endfunction

    logic                accept;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_base;
    logic [CNT_W-1:0]    count_inc;
    logic                window_full;
    logic [DIV_W-1:0]    sum_l_reg, sum_l_next;
    logic [DIV_W-1:0]    sum_r_reg, sum_r_next;
    logic [DUTY_W-1:0]   duty_l_reg, duty_l_next;
    logic [DUTY_W-1:0]   duty_r_reg, duty_r_next;
    logic [TARGET_W-1:0] target_l_reg;
    logic [TARGET_W-1:0] target_r_reg;
    logic [RPM_W-1:0]    rpm_l_reg;
    logic [RPM_W-1:0]    rpm_r_reg;
    logic                sat_l_reg;
    logic                sat_r_reg;
    logic                m_valid_reg;
    logic [RPM_W-1:0]    out_rpm_l_reg;
    logic [RPM_W-1:0]    out_rpm_r_reg;
    logic [DUTY_W-1:0]   out_duty_l_reg;
    logic [DUTY_W-1:0]   out_duty_r_reg;
    logic                out_sat_reg;
    logic                out_free;

    logic [DIV_W-1:0]    avg_sum;
    logic [PROD_W-1:0]   avg_prod;
    logic [DVSR_W-1:0]   div_divisor;
    logic                div_busy;
    logic                div_done;
    logic [DIV_W-1:0]    div_quotient;
    logic                rpm_over;
    logic [RPM_W-1:0]    rpm_sat;

    assign accept      = s_tvalid && cmd.in_ready;
    assign count_base  = restart ? '0 : count_reg;
    assign count_inc   = count_base + CNT_W'(1);
    assign window_full = (count_inc == CNT_W'(WINDOW));
    assign sum_l_next  = (restart ? '0 : sum_l_reg) + DIV_W'(left_period);
    assign sum_r_next  = (restart ? '0 : sum_r_reg) + DIV_W'(right_period);
    assign duty_l_next = step_duty(duty_l_reg, rpm_l_reg, target_l_reg);
    assign duty_r_next = step_duty(duty_r_reg, rpm_r_reg, target_r_reg);
    assign out_free    = !m_valid_reg || m_tready;

    // Window average by reciprocal multiplication; the divider latches it at start
    assign avg_sum     = (cmd.div_sel == SEL_RIGHT_RPM) ? sum_r_reg : sum_l_reg;
    assign avg_prod    = PROD_W'(avg_sum) * PROD_W'(AVG_RECIP);
    assign div_divisor = avg_prod[PROD_W-1:RECIP_SHIFT];

    tws_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (RPM_NUMERATOR),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // A zero average divides to all ones, so it saturates here as well
    assign rpm_over = (div_quotient > DIV_W'(RPM_MAX));
    assign rpm_sat  = rpm_over ? RPM_MAX : div_quotient[RPM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            sum_l_reg    <= '0;
            sum_r_reg    <= '0;
            duty_l_reg   <= DUTY_RESET;
            duty_r_reg   <= DUTY_RESET;
            target_l_reg <= TARGET_RESET;
            target_r_reg <= TARGET_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                sum_l_reg <= sum_l_next;
                sum_r_reg <= sum_r_next;
                count_reg <= window_full ? '0 : count_inc;
            end
            if (cmd.emit) begin
                sum_l_reg   <= '0;
                sum_r_reg   <= '0;
                duty_l_reg  <= duty_l_next;
                duty_r_reg  <= duty_r_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_TARGET_LEFT:  target_l_reg <= cfg_data[TARGET_W-1:0];
                    REG_TARGET_RIGHT: target_r_reg <= cfg_data[TARGET_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_done) begin
            unique case (cmd.div_sel)
                SEL_LEFT_RPM: begin
                    rpm_l_reg <= rpm_sat;
                    sat_l_reg <= rpm_over;
                end
                SEL_RIGHT_RPM: begin
                    rpm_r_reg <= rpm_sat;
                    sat_r_reg <= rpm_over;
                end
            endcase
        end
        if (cmd.emit) begin
            out_rpm_l_reg  <= rpm_l_reg;
            out_rpm_r_reg  <= rpm_r_reg;
            out_duty_l_reg <= duty_l_next;
            out_duty_r_reg <= duty_r_next;
            out_sat_reg    <= sat_l_reg || sat_r_reg;
        end
    end

    assign status.win_end  = accept && window_full;
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;
    assign status.out_free = out_free;

    assign m_tvalid        = m_valid_reg;
    assign left_rpm        = out_rpm_l_reg;
    assign right_rpm       = out_rpm_r_reg;
    assign left_duty       = out_duty_l_reg;
    assign right_duty      = out_duty_r_reg;
    assign speed_saturated = out_sat_reg;

endmodule

FILE: rtl/tws_ctrl.sv
// Controller: sequences the two rpm divisions and the result hand-off after each window.
module tws_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  tws_pkg::dp_status_t status,
    output tws_pkg::dp_cmd_t    cmd
);
    import tws_pkg::*;

    state_t state_reg, state_next;
    logic   launch;

    // start a division once the shared unit is free and has not just finished
    assign launch = !status.div_busy && !status.div_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd.in_ready  = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = SEL_LEFT_RPM;
        cmd.emit      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (status.win_end) begin
                    state_next = ST_LEFT_RPM;
                end
            end
            ST_LEFT_RPM: begin
                cmd.div_sel   = SEL_LEFT_RPM;
                cmd.div_start = launch;
                if (status.div_done) begin
                    state_next = ST_RIGHT_RPM;
                end
            end
            ST_RIGHT_RPM: begin
                cmd.div_sel   = SEL_RIGHT_RPM;
                cmd.div_start = launch;
                if (status.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the output register can take the beat
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
